### sv/dezu_pkg.sv
package dezu_pkg;

  localparam int WORD_W  = 32;
  localparam int CHAN_W  = 3;
  localparam int SIDX_W  = 22;
  localparam int RUN_W   = 21;
  localparam int SIZE_W  = 28;
  localparam int GOOD_W  = 20;
  localparam int POP_W   = 4;

  localparam logic [2:0] KIND_PAIR     = 3'd0;
  localparam logic [2:0] KIND_BASELINE = 3'd1;
  localparam logic [2:0] KIND_EVT_END  = 3'd2;
  localparam logic [2:0] KIND_FMT_ERR  = 3'd3;
  localparam logic [2:0] KIND_IDX_OVF  = 3'd4;

  localparam logic [11:0] HDR_TAG   = 12'hA00;
  localparam logic [31:0] FILL_WORD = 32'hFFFF_FFFF;

  localparam logic REG_ZLE_ENABLE    = 1'b0;
  localparam logic REG_BASELINE_FILL = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              buffer_start;
  } in_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [CHAN_W-1:0] channel;
    logic [SIDX_W-1:0] sample_index;
    logic [15:0]       sample_low;
    logic [15:0]       sample_high;
    logic [RUN_W-1:0]  run_length;
    logic              last;
  } out_t;

  // Classified beat handed from front to back.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              bstart;
    logic              ones;
  } q_t;

  typedef struct packed {
    logic              start;
    logic [SIZE_W-1:0] dividend;
    logic [POP_W-1:0]  divisor;
  } div_cmd_t;

  typedef struct packed {
    logic              busy;
    logic [SIZE_W-1:0] quotient;
  } div_rsp_t;

endpackage

### sv/dezu_front.sv
module dezu_front import dezu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_item,
  output logic q_valid,
  input  logic q_take,
  output q_t   q_item
);

  q_t         mem [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] cnt;
  logic       push;
  logic       pop;

  assign in_ready = (cnt != 3'd4);
  assign push     = in_valid && in_ready;
  assign pop      = q_take && q_valid;
  assign q_valid  = (cnt != 3'd0);
  assign q_item   = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= '{word: in_item.word, bstart: in_item.buffer_start,
                   ones: (in_item.word == FILL_WORD)};
    end
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop)  rp <= rp + 2'd1;
      cnt <= cnt + {2'b0, push} - {2'b0, pop};
    end
  end

endmodule

### sv/dezu_div.sv
module dezu_div import dezu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_cmd_t cmd,
  output div_rsp_t rsp
);

  logic [SIZE_W-1:0] dq;
  logic [POP_W-1:0]  rem;
  logic [POP_W-1:0]  dvs;
  logic [4:0]        steps;
  logic              busy;
  logic [POP_W:0]    trial;
  logic              qbit;

  assign trial = {rem, dq[SIZE_W-1]};
  assign qbit  = (trial >= {1'b0, dvs});
  assign rsp   = '{busy: busy, quotient: dq};

  // restoring divide, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dq  <= cmd.dividend;
      rem <= '0;
      dvs <= cmd.divisor;
    end else if (busy) begin
      dq  <= {dq[SIZE_W-2:0], qbit};
      rem <= qbit ? POP_W'(trial - {1'b0, dvs}) : trial[POP_W-1:0];
    end
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (cmd.start) begin
      busy  <= 1'b1;
      steps <= 5'(SIZE_W);
    end else if (busy) begin
      steps <= steps - 5'd1;
      busy  <= (steps != 5'd1);
    end
  end

endmodule

### sv/dezu_back.sv
module dezu_back import dezu_pkg::*; #(
  parameter int NUM_CHANNELS = 8,
  parameter int INDEX_BITS   = 22
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_take,
  input  q_t          q_item,
  input  logic        zle_enable,
  input  logic [15:0] baseline_fill,
  output div_cmd_t    div_cmd,
  input  div_rsp_t    div_rsp,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_item
);

  localparam logic [3:0] PH_HDR    = 4'd0;
  localparam logic [3:0] PH_MASK   = 4'd1;
  localparam logic [3:0] PH_CNT1   = 4'd2;
  localparam logic [3:0] PH_CNT2   = 4'd3;
  localparam logic [3:0] PH_RAW    = 4'd4;
  localparam logic [3:0] PH_CHSIZE = 4'd5;
  localparam logic [3:0] PH_CTRL   = 4'd6;
  localparam logic [3:0] PH_GOOD   = 4'd7;
  localparam logic [3:0] PH_DRAIN  = 4'd8;

  localparam int SW = (INDEX_BITS > RUN_W ? INDEX_BITS : RUN_W) + 2;
  localparam logic [SW-1:0] IDX_MAX = SW'({INDEX_BITS{1'b1}});
  localparam logic [7:0] CH_MASK = 8'((1 << NUM_CHANNELS) - 1);

  logic [3:0]            phase, phase_next;
  logic [SIZE_W-1:0]     payload, payload_next;
  logic [7:0]            mask, mask_next;
  logic [CHAN_W-1:0]     chan, chan_next;
  logic [SIZE_W-1:0]     chleft, chleft_next;
  logic [GOOD_W-1:0]     good, good_next;
  logic [INDEX_BITS-1:0] scnt, scnt_next;
  logic                  zle_ev, zle_ev_next;

  out_t       ob0, ob1;
  logic [1:0] ocnt;

  logic       a_v, b_v;
  out_t       a, b;
  logic [1:0] nres;

  function automatic out_t mk(logic [2:0] k, logic [CHAN_W-1:0] c, logic [SIDX_W-1:0] i,
                              logic [15:0] l, logic [15:0] h, logic [RUN_W-1:0] r);
    out_t o;
    o = '{kind: k, channel: c, sample_index: i, sample_low: l, sample_high: h,
          run_length: r, last: 1'b0};
    return o;
  endfunction

  assign out_valid = (ocnt != 2'd0);
  assign out_item  = ob0;
  assign q_take    = q_valid && !div_rsp.busy &&
                     (ocnt == 2'd0 || (ocnt == 2'd1 && out_ready));

  always_comb begin
    logic [WORD_W-1:0] w;
    logic              do_put;
    logic              put_run;
    logic [RUN_W-1:0]  put_n;
    logic [15:0]       put_lo;
    logic [15:0]       put_hi;
    logic              do_enter;
    logic [3:0]        from;
    logic [SW-1:0]     sum;
    logic [7:0]        mm;
    logic [POP_W-1:0]  pop;
    logic              found;
    logic [CHAN_W-1:0] fch;
    logic [SIZE_W-1:0] s;

    w            = q_item.word;
    phase_next   = phase;
    payload_next = payload;
    mask_next    = mask;
    chan_next    = chan;
    chleft_next  = chleft;
    good_next    = good;
    scnt_next    = scnt;
    zle_ev_next  = zle_ev;
    do_put   = 1'b0;
    put_run  = 1'b0;
    put_n    = '0;
    put_lo   = w[15:0];
    put_hi   = w[31:16];
    do_enter = 1'b0;
    from     = '0;
    a_v = 1'b0;
    b_v = 1'b0;
    a   = '0;
    b   = '0;
    sum = '0;
    mm  = w[7:0] & CH_MASK;
    pop = POP_W'($countones(mm));
    found = 1'b0;
    fch   = '0;
    s     = w[SIZE_W-1:0];
    div_cmd = '{start: 1'b0, dividend: payload, divisor: pop};

    if (q_item.bstart) phase_next = PH_HDR;

    if (!(q_item.bstart && q_item.ones)) begin
      unique case (phase_next)
        PH_HDR: begin
          if (w[31:20] == HDR_TAG) begin
            payload_next = (s > SIZE_W'(4)) ? s - SIZE_W'(4) : '0;
            phase_next   = PH_MASK;
          end else begin
            chan_next = '0;
            a_v = 1'b1;
            a   = mk(KIND_FMT_ERR, '0, '0, '0, '0, '0);
          end
        end
        PH_MASK: begin
          chan_next = '0;
          if (w[31:28] != 4'd0) begin
            a_v = 1'b1;
            a   = mk(KIND_FMT_ERR, '0, '0, '0, '0, '0);
            phase_next = PH_HDR;
          end else if (payload_next == '0) begin
            a_v = 1'b1;
            a   = mk(KIND_EVT_END, '0, '0, '0, '0, '0);
            phase_next = PH_HDR;
          end else if (pop == '0) begin
            a_v = 1'b1;
            a   = mk(KIND_EVT_END, '0, '0, '0, '0, '0);
            phase_next = PH_DRAIN;
          end else begin
            mask_next     = mm;
            div_cmd.start = q_take;
            zle_ev_next   = zle_enable;
            phase_next    = PH_CNT1;
          end
        end
        PH_CNT1: phase_next = PH_CNT2;
        PH_CNT2: do_enter = 1'b1;
        PH_RAW: begin
          if (payload_next != '0) payload_next = payload_next - SIZE_W'(1);
          do_put = 1'b1;
          put_n  = RUN_W'(2);
          if (chleft_next != '0) chleft_next = chleft_next - SIZE_W'(1);
          if (chleft_next == '0) begin
            do_enter = 1'b1;
            from     = 4'(chan) + 4'd1;
          end
        end
        PH_CHSIZE: begin
          if (payload_next != '0) payload_next = payload_next - SIZE_W'(1);
          if (s <= SIZE_W'(1)) begin
            do_enter = 1'b1;
            from     = 4'(chan) + 4'd1;
          end else begin
            chleft_next = s - SIZE_W'(1);
            phase_next  = PH_CTRL;
          end
        end
        PH_CTRL: begin
          if (payload_next != '0) payload_next = payload_next - SIZE_W'(1);
          if (chleft_next != '0) chleft_next = chleft_next - SIZE_W'(1);
          if (w[31]) begin
            good_next = w[GOOD_W-1:0];
            if (w[GOOD_W-1:0] != '0) phase_next = PH_GOOD;
          end else begin
            do_put  = 1'b1;
            put_run = 1'b1;
            put_n   = {w[GOOD_W-1:0], 1'b0};
            put_lo  = baseline_fill;
            put_hi  = '0;
          end
          if (chleft_next == '0) begin
            do_enter = 1'b1;
            from     = 4'(chan) + 4'd1;
          end
        end
        PH_GOOD: begin
          if (payload_next != '0) payload_next = payload_next - SIZE_W'(1);
          do_put = 1'b1;
          put_n  = RUN_W'(2);
          if (chleft_next != '0) chleft_next = chleft_next - SIZE_W'(1);
          if (good_next != '0) good_next = good_next - GOOD_W'(1);
          if (good_next == '0) phase_next = PH_CTRL;
          if (chleft_next == '0) begin
            do_enter = 1'b1;
            from     = 4'(chan) + 4'd1;
          end
        end
        PH_DRAIN: begin
          if (payload_next != '0) payload_next = payload_next - SIZE_W'(1);
          if (payload_next == '0) phase_next = PH_HDR;
        end
        default: phase_next = PH_HDR;
      endcase
    end

    // pair or run: index check, then saturating advance
    if (do_put) begin
      sum = SW'(scnt) + SW'(put_n);
      a_v = 1'b1;
      if (sum > IDX_MAX + SW'(1)) begin
        a = mk(KIND_IDX_OVF, chan, SIDX_W'(scnt), '0, '0, '0);
      end else if (put_run) begin
        a = mk(KIND_BASELINE, chan, SIDX_W'(scnt), put_lo, '0, put_n);
      end else begin
        a = mk(KIND_PAIR, chan, SIDX_W'(scnt), put_lo, put_hi, '0);
      end
      scnt_next = (sum > IDX_MAX) ? INDEX_BITS'(IDX_MAX) : INDEX_BITS'(sum);
    end

    // next enabled channel at or above 'from', else close the event
    if (do_enter) begin
      for (int j = 0; j < NUM_CHANNELS; j++) begin
        if (!found && 4'(j) >= from && mask_next[j]) begin
          found = 1'b1;
          fch   = CHAN_W'(j);
        end
      end
      if (found && (zle_ev_next || div_rsp.quotient != '0)) begin
        chan_next  = fch;
        scnt_next  = '0;
        phase_next = zle_ev_next ? PH_CHSIZE : PH_RAW;
        if (!zle_ev_next) chleft_next = div_rsp.quotient;
      end else begin
        b_v = 1'b1;
        b   = mk(KIND_EVT_END, chan_next, '0, '0, '0, '0);
        phase_next = (payload_next != '0) ? PH_DRAIN : PH_HDR;
      end
    end

    a.last = !b_v;
    b.last = 1'b1;
    nres   = {1'b0, a_v} + {1'b0, b_v};
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      ob0 <= a_v ? a : b;
      ob1 <= b;
    end else if (out_valid && out_ready) begin
      ob0 <= ob1;
    end
    if (rst) begin
      phase   <= PH_HDR;
      payload <= '0;
      mask    <= '0;
      chan    <= '0;
      chleft  <= '0;
      good    <= '0;
      scnt    <= '0;
      zle_ev  <= 1'b0;
      ocnt    <= '0;
    end else begin
      if (q_take) begin
        phase   <= phase_next;
        payload <= payload_next;
        mask    <= mask_next;
        chan    <= chan_next;
        chleft  <= chleft_next;
        good    <= good_next;
        scnt    <= scnt_next;
        zle_ev  <= zle_ev_next;
        ocnt    <= nres;
      end else if (out_valid && out_ready) begin
        ocnt <= ocnt - 2'd1;
      end
    end
  end

  a_ocnt_range: assert property (@(posedge clk) disable iff (rst) ocnt != 2'd3)
    else $error("result buffer count out of range");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    q_take |-> !div_rsp.busy)
    else $error("word taken while divider busy");
  a_first_not_last: assert property (@(posedge clk) disable iff (rst)
    ocnt == 2'd2 |-> !ob0.last && ob1.last)
    else $error("last flag misplaced in result pair");
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ob0.kind <= KIND_IDX_OVF)
    else $error("result kind out of range");

endmodule

### sv/digitizer_event_zle_unpacker.sv
// Digitizer event unpacker, raw or zero-length-encoded channel data.
// in_valid/in_ready/in_item: one 32-bit readout word per beat, with a
//   buffer_start flag on the first word of a readout buffer.
// out_valid/out_ready/out_item: result beats (sample pair, baseline run,
//   event end, format error, index overflow); last marks the final result
//   of one input word. A word yields zero, one or two results.
// APB port: reg 0 (addr 0) zle_enable, reg 1 (addr 4) baseline_fill.
//   Mode is latched per event at the mask word; write only when idle.
// A 4-deep input queue decouples the front from the back, which decodes
// one word per cycle, while the divider is idle and results drain, into
// a two-entry result buffer. A word that gives two results holds the back
// for two output beats. Each word is registered in the queue, then its results in the result buffer.
// Throughput: one word per cycle while results drain; the mask word starts
//   a radix-2 divide (payload / enabled channels), and the back stalls on
//   words after it until the quotient is ready.
// Reset (rst, synchronous) empties the queue and result buffer and returns
// the decoder to waiting for a header word.
// A stalled receiver backs up the result buffer, then the queue, then
// in_ready drops; nothing is dropped.
module digitizer_event_zle_unpacker import dezu_pkg::*; #(
  parameter int NUM_CHANNELS = 8,
  parameter int INDEX_BITS   = 22
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        zle_enable;
  logic [15:0] baseline_fill;
  logic        q_valid;
  logic        q_take;
  q_t          q_item;
  div_cmd_t    div_cmd;
  div_rsp_t    div_rsp;

  // config registers
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BASELINE_FILL) ? {16'b0, baseline_fill}
                                                  : {31'b0, zle_enable};

  always_ff @(posedge clk) begin
    if (rst) begin
      zle_enable    <= 1'b0;
      baseline_fill <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_ZLE_ENABLE) zle_enable <= pwdata[0];
      else baseline_fill <= pwdata[15:0];
    end
  end

  dezu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_take   (q_take),
    .q_item   (q_item)
  );

  dezu_div u_div (
    .clk (clk),
    .rst (rst),
    .cmd (div_cmd),
    .rsp (div_rsp)
  );

  dezu_back #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .INDEX_BITS   (INDEX_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_take        (q_take),
    .q_item        (q_item),
    .zle_enable    (zle_enable),
    .baseline_fill (baseline_fill),
    .div_cmd       (div_cmd),
    .div_rsp       (div_rsp),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item)
  );

endmodule

### bench/tb_digitizer_event_zle_unpacker.sv
`timescale 1ns / 1ps

// Bench for the digitizer event unpacker.
// A local decoder model tracks every accepted input beat and queues the
// result beats it must cause; a monitor pops them in order on each output
// beat and compares every field.
module tb_digitizer_event_zle_unpacker;
  import dezu_pkg::*;

  localparam int            NCH       = 8;
  localparam int            IDXB      = 22;
  localparam longint        IDX_TOP   = (64'd1 << IDXB) - 1;
  localparam int            WDOG_MAX  = 4000;
  localparam int            RAND_WORDS = 1650;
  localparam logic [31:0]   HDR_BASE  = {HDR_TAG, 20'd0};

  // decoder phases of the local model
  typedef enum logic [3:0] {
    S_HEADER, S_MASKW, S_COUNT1, S_COUNT2, S_RAWDATA,
    S_CHSIZE, S_CONTROL, S_GOODRUN, S_DRAIN
  } dec_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  always #10 clk = ~clk;

  digitizer_event_zle_unpacker #(.NUM_CHANNELS(NCH), .INDEX_BITS(IDXB)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // ---------------- decoder model state ----------------
  dec_phase_t  st;
  int unsigned payload_left, ch_left, good_left, raw_per_ch;
  logic [7:0]  ch_mask;
  int          cur_ch;
  longint      samp_cnt;
  bit          evt_zle, cfg_zle;
  logic [15:0] cfg_fill;

  out_t staged[$];        // results of the word being decoded
  out_t expected_beats[$];

  int n_words, n_results, n_errors, n_events;
  int idle_cnt;
  bit no_gaps;            // stretch with no sender idling
  logic [31:0] evt_words[$];
  logic        evt_bs[$];

  function automatic void add_result(logic [2:0] kind, longint idx, logic [15:0] lo,
                                     logic [15:0] hi, longint run);
    out_t r;
    r.kind = kind;
    r.channel = cur_ch[2:0];
    r.sample_index = idx[SIDX_W-1:0];
    r.sample_low = lo;
    r.sample_high = hi;
    r.run_length = run[RUN_W-1:0];
    r.last = 1'b0;
    staged.insert(staged.size(), r);
  endfunction

  // pair or baseline run; flags index overflow, counter saturates
  function automatic void add_samples(bit is_run, logic [15:0] lo, logic [15:0] hi,
                                      longint n);
    longint c;
    c = samp_cnt;
    if (c + n > IDX_TOP + 1) add_result(KIND_IDX_OVF, c, '0, '0, 0);
    else if (is_run) add_result(KIND_BASELINE, c, lo, '0, n);
    else add_result(KIND_PAIR, c, lo, hi, 0);
    c += n;
    if (c > IDX_TOP) c = IDX_TOP;
    samp_cnt = c;
  endfunction

  function automatic void open_channel(int from);
    for (int ch = from; ch < NCH; ch++) begin
      if (!ch_mask[ch]) continue;
      if (evt_zle) begin
        cur_ch = ch; samp_cnt = 0; st = S_CHSIZE;
        return;
      end
      if (raw_per_ch > 0) begin
        cur_ch = ch; samp_cnt = 0; ch_left = raw_per_ch; st = S_RAWDATA;
        return;
      end
    end
    add_result(KIND_EVT_END, 0, '0, '0, 0);
    st = (payload_left != 0) ? S_DRAIN : S_HEADER;
  endfunction

  function automatic void take_payload();
    if (payload_left != 0) payload_left--;
  endfunction

  function automatic void decode_word(logic [31:0] w, logic bs);
    int pop;
    logic [7:0] m;
    logic [27:0] s;
    logic [19:0] n;
    if (bs) begin
      st = S_HEADER;
      if (w == FILL_WORD) return;
    end
    case (st)
      S_HEADER: begin
        if (w[31:20] == HDR_TAG) begin
          payload_left = (w[27:0] > 4) ? w[27:0] - 4 : 0;
          st = S_MASKW;
        end else begin
          cur_ch = 0;
          add_result(KIND_FMT_ERR, 0, '0, '0, 0);
        end
      end
      S_MASKW: begin
        cur_ch = 0;
        if (w[31:28] != 0) begin
          add_result(KIND_FMT_ERR, 0, '0, '0, 0);
          st = S_HEADER;
        end else if (payload_left == 0) begin
          add_result(KIND_EVT_END, 0, '0, '0, 0);
          st = S_HEADER;
        end else begin
          m = w[7:0];
          pop = $countones(m);
          if (pop == 0) begin
            add_result(KIND_EVT_END, 0, '0, '0, 0);
            st = S_DRAIN;
          end else begin
            ch_mask = m;
            raw_per_ch = payload_left / pop;
            evt_zle = cfg_zle;
            st = S_COUNT1;
          end
        end
      end
      S_COUNT1: st = S_COUNT2;
      S_COUNT2: open_channel(0);
      S_RAWDATA: begin
        take_payload();
        add_samples(1'b0, w[15:0], w[31:16], 2);
        if (ch_left != 0) ch_left--;
        if (ch_left == 0) open_channel(cur_ch + 1);
      end
      S_CHSIZE: begin
        s = w[27:0];
        take_payload();
        if (s <= 1) open_channel(cur_ch + 1);
        else begin
          ch_left = s - 1;
          st = S_CONTROL;
        end
      end
      S_CONTROL: begin
        n = w[19:0];
        take_payload();
        if (ch_left != 0) ch_left--;
        if (w[31]) begin
          good_left = n;
          if (n > 0) st = S_GOODRUN;
        end else begin
          add_samples(1'b1, cfg_fill, '0, longint'(n) * 2);
        end
        if (ch_left == 0) open_channel(cur_ch + 1);
      end
      S_GOODRUN: begin
        take_payload();
        add_samples(1'b0, w[15:0], w[31:16], 2);
        if (ch_left != 0) ch_left--;
        if (good_left != 0) good_left--;
        if (good_left == 0) st = S_CONTROL;
        if (ch_left == 0) open_channel(cur_ch + 1);
      end
      S_DRAIN: begin
        take_payload();
        if (payload_left == 0) st = S_HEADER;
      end
      default: st = S_HEADER;
    endcase
  endfunction

  // ---------------- handshake helpers ----------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(logic [31:0] w, logic bs);
    int g;
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= '{word: w, buffer_start: bs};
    do @(posedge clk); while (!in_ready);
    decode_word(w, bs);
    if (staged.size() > 0) staged[$].last = 1'b1;
    foreach (staged[i]) expected_beats.insert(expected_beats.size(), staged[i]);
    staged.delete();
    n_words++;
  endtask

  // hold input, let every queued result come out, then cover the divide
  // and pipeline so words that cause no result have also been consumed
  task automatic wait_quiet();
    @(negedge clk) in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic reg_write(logic idx, logic [31:0] val);
    logic [31:0] exp_rd;
    wait_quiet();
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    // read back through the same address
    exp_rd = (idx == REG_ZLE_ENABLE) ? {31'b0, val[0]} : {16'b0, val[15:0]};
    if (prdata !== exp_rd) begin
      $error("prdata mismatch: expected %0h, got %0h", exp_rd, prdata);
      n_errors++;
    end
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_ZLE_ENABLE) cfg_zle = val[0];
    else cfg_fill = val[15:0];
  endtask

  task automatic flush_event();
    foreach (evt_words[i]) send_word(evt_words[i], evt_bs[i]);
    evt_words.delete();
    evt_bs.delete();
    n_events++;
  endtask

  function automatic void push(logic [31:0] w, logic bs = 1'b0);
    evt_words.insert(evt_words.size(), w);
    evt_bs.insert(evt_bs.size(), bs);
  endfunction

  // one ZLE channel body: size word then control / data words
  function automatic void zle_channel(ref logic [31:0] q[$]);
    logic [31:0] body[$];
    int nctl, ngood, ndat;
    if ($urandom_range(0, 9) == 0) begin
      q.insert(q.size(), {4'($urandom), 27'd0, 1'($urandom)});   // empty channel
      return;
    end
    nctl = $urandom_range(1, 4);
    for (int c = 0; c < nctl; c++) begin
      if ($urandom_range(0, 1)) begin
        body.insert(body.size(), {1'b0, 11'($urandom),
                                  ($urandom_range(0, 15) == 0) ? 20'($urandom) :
                                  20'($urandom_range(0, 8))});
      end else begin
        ngood = $urandom_range(0, 3);
        ndat = ngood;
        if (c == nctl - 1 && ngood > 1 && $urandom_range(0, 3) == 0)
          ndat = ngood - 1;                                // run cut off
        body.insert(body.size(), {1'b1, 11'($urandom), 20'(ngood)});
        repeat (ndat) body.insert(body.size(), $urandom);
      end
    end
    q.insert(q.size(), {4'($urandom), 28'(body.size() + 1)});
    foreach (body[i]) q.insert(q.size(), body[i]);
  endfunction

  // well-formed event with random content in the current mode;
  // cut > 0 keeps at most that many words (broken event)
  task automatic build_event(int cut = 0);
    logic [31:0] data[$];
    logic [7:0]  m;
    int pop, wpc, plen, trail;
    m = 8'($urandom);
    if (m == 0) m = 8'h01;
    pop = $countones(m);
    if (cfg_zle) begin
      for (int ch = 0; ch < NCH; ch++) if (m[ch]) zle_channel(data);
    end else begin
      wpc = $urandom_range(1, 5);
      plen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, pop - 1) : pop * wpc;
      repeat (plen) data.insert(data.size(), $urandom);
    end
    trail = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    repeat (trail) data.insert(data.size(), $urandom);
    if ($urandom_range(0, 2) == 0) begin
      push(FILL_WORD, 1'b1);
      push(HDR_BASE | 32'(data.size() + 4));
    end else begin
      push(HDR_BASE | 32'(data.size() + 4), 1'b1);
    end
    push({4'd0, 20'($urandom), m});
    push($urandom);
    push($urandom);
    foreach (data[i]) push(data[i]);
    if (cut > 0) while (evt_words.size() > cut) begin
      void'(evt_words.pop_back());
      void'(evt_bs.pop_back());
    end
    flush_event();
  endtask

  // ---------------- output side ----------------
  int ready_run;
  always @(negedge clk) begin
    if (ready_run == 0) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        ready_run = $urandom_range(1, 20);
        out_ready <= 1'b1;
      end else begin
        ready_run = (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 50);
        out_ready <= 1'b0;
      end
    end else begin
      ready_run--;
    end
  end

  function automatic void check_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s mismatch: expected %0h, got %0h", name, e, a);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat kind %0d", out_item.kind);
        n_errors++;
      end else begin
        out_t e;
        e = expected_beats.pop_front();
        check_field("kind", e.kind, out_item.kind);
        check_field("channel", e.channel, out_item.channel);
        check_field("sample_index", e.sample_index, out_item.sample_index);
        check_field("sample_low", e.sample_low, out_item.sample_low);
        check_field("sample_high", e.sample_high, out_item.sample_high);
        check_field("run_length", e.run_length, out_item.run_length);
        check_field("last", e.last, out_item.last);
      end
      n_results++;
    end
  end

  // watchdog: no beat on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WDOG_MAX) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_header_errors();
    push(32'h1234_5678, 1'b1);        // bad tag
    push(HDR_BASE | 32'd10);
    push(32'h1000_00FF);              // mask with high nibble set
    push(HDR_BASE | 32'd4);           // empty event
    push(32'h0000_0003);
    push(HDR_BASE | 32'd7);           // empty mask, payload drained
    push(32'h0FFF_FF00);
    repeat (3) push(32'hFFFF_FFFF);
    push(FILL_WORD, 1'b1);            // dropped
    push(32'h0000_0000);              // bad tag after buffer start
    flush_event();
  endtask

  task automatic test_raw_cases();
    push(HDR_BASE | 32'd8, 1'b1);     // mask 0x81, two words per channel
    push(32'h0000_0081); push('0); push('1);
    push(32'hFFFF_0000); push(32'h0000_FFFF); push(32'h8000_0001); push(32'hDEAD_BEEF);
    push(HDR_BASE | 32'd6, 1'b1);     // short raw: 2 words, 3 channels
    push(32'h0000_0007); push('0); push('0); push('1); push('1);
    push(HDR_BASE | 32'd9, 1'b1);     // aborted mid-channel by the next buffer start
    push(32'h0000_0002); push('0); push('0); push(32'h5555_AAAA);
    push(HDR_BASE | 32'd7, 1'b1);     // one channel of three words, no trailing words
    push(32'h0000_0040); push('0); push('0); push(32'h0102_0304); push('1); push('1);
    flush_event();
  endtask

  task automatic test_zle_cases();
    reg_write(REG_ZLE_ENABLE, 32'd1);
    reg_write(REG_BASELINE_FILL, 32'h0000_FFFF);
    // ch0 empty, ch1: skip, good N=0, good N=2, cut-off good run
    push(HDR_BASE | 32'd12, 1'b1);
    push(32'h0000_0003); push('0); push('0);
    push(32'h0000_0001);
    push(32'h0000_0007);
    push(32'h0000_0003); push(32'h8000_0000); push(32'h8000_0002);
    push(32'h1111_2222); push(32'h3333_4444); push(32'h8000_0005);
    flush_event();
    wait_quiet();                     // sender holds until all results are in
    reg_write(REG_BASELINE_FILL, 32'h0000_0000);
    // index overflow and saturation, zero-length run stays legal
    push(HDR_BASE | 32'd12, 1'b1);
    push(32'h0000_0010); push('0); push('0);
    push(32'h0000_0008);
    push(32'h000F_FFFF); push(32'h000F_FFFF); push(32'h000F_FFFF);
    push(32'h0000_0000); push(32'h8000_0001); push(32'hCAFE_F00D);
    push(32'h7FFF_FFFF);
    flush_event();
  endtask

  task automatic test_random_events();
    int burst;
    while (n_words < RAND_WORDS) begin
      if ($urandom_range(0, 24) == 0) begin
        reg_write(REG_ZLE_ENABLE, $urandom_range(0, 1));
        reg_write(REG_BASELINE_FILL, $urandom);
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      case ($urandom_range(0, 9))
        0: begin
          burst = $urandom_range(1, 4);
          repeat (burst) push($urandom, ($urandom_range(0, 3) == 0));
          flush_event();
        end
        1: build_event($urandom_range(1, 8));
        default: build_event();
      endcase
    end
  endtask

  initial begin
    st = S_HEADER; payload_left = 0; ch_mask = '0; cur_ch = 0; ch_left = 0;
    good_left = 0; samp_cnt = 0; raw_per_ch = 0; evt_zle = 0;
    cfg_zle = 0; cfg_fill = '0;
    n_words = 0; n_results = 0; n_errors = 0; n_events = 0;
    idle_cnt = 0; ready_run = 0; no_gaps = 0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_header_errors();
    test_raw_cases();
    test_zle_cases();
    reg_write(REG_ZLE_ENABLE, 32'd0);
    test_random_events();

    wait_quiet();
    $display("Covered %0d words in %0d sequences, %0d result beats checked,", n_words,
             n_events, n_results);
    $display("raw and ZLE modes, errors, aborts, overflow, fill values 0 to 0xFFFF.");
    if (n_errors == 0 && expected_beats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### digitizer_event_zle_unpacker.f
sv/dezu_pkg.sv
sv/dezu_front.sv
sv/dezu_div.sv
sv/dezu_back.sv
sv/digitizer_event_zle_unpacker.sv
bench/tb_digitizer_event_zle_unpacker.sv
